/* sv/acrfd_pkg.sv */
// acrfd_pkg: constants, result codes and code lookup functions for the remote frame decoder
// no dependencies; imported by ac_remote_frame_decoder and tb
`timescale 1ns / 1ps

package acrfd_pkg;

  // frame layout
  localparam logic [3:0] PosHdr0     = 4'd0;
  localparam logic [3:0] PosHdr1     = 4'd1;
  localparam logic [3:0] PosHdr2     = 4'd2;
  localparam logic [3:0] PosTemp     = 4'd4;
  localparam logic [3:0] PosPower    = 4'd5;
  localparam logic [3:0] PosModeFan  = 4'd6;
  localparam logic [3:0] PosFlap     = 4'd8;
  localparam logic [3:0] PosChecksum = 4'd12;
  localparam logic [3:0] PosMax      = 4'd15;

  localparam logic [7:0] Hdr0Byte = 8'hAA;
  localparam logic [7:0] Hdr1Byte = 8'h5A;
  localparam logic [7:0] Hdr2Byte = 8'hCF;

  localparam logic [8:0] TempOffset   = 9'd17;
  localparam logic [8:0] TempMaintain = 9'd10;

  typedef enum logic [1:0] {
    PowerUnknown  = 2'd0,
    PowerOff      = 2'd1,
    PowerOn       = 2'd2,
    PowerTimerOff = 2'd3
  } power_e;

  typedef enum logic [2:0] {
    ModeUnknown  = 3'd0,
    ModeMaintain = 3'd1,
    ModeHeat     = 3'd2,
    ModeCool     = 3'd3,
    ModeDry      = 3'd4,
    ModeIon      = 3'd5
  } mode_e;

  typedef enum logic [2:0] {
    FanUnknown = 3'd0,
    FanAuto    = 3'd1,
    FanSpeed1  = 3'd2,
    FanSpeed2  = 3'd3,
    FanSpeed3  = 3'd4,
    FanSpeed4  = 3'd5
  } fan_e;

  typedef enum logic [2:0] {
    FlapUnknown    = 3'd0,
    FlapAuto       = 3'd1,
    FlapTop        = 3'd2,
    FlapTopMiddle  = 3'd3,
    FlapMiddle     = 3'd4,
    FlapMiddleDown = 3'd5,
    FlapDown       = 3'd6
  } flap_e;

  function automatic power_e power_code(input logic [7:0] b);
    power_e code;
    unique case (b)
      8'h21:   code = PowerOff;
      8'h31:   code = PowerOn;
      8'h81:   code = PowerTimerOff;
      default: code = PowerUnknown;
    endcase
    return code;
  endfunction

  function automatic mode_e mode_code(input logic [7:0] b, input logic [7:0] temp);
    mode_e code;
    unique case (b[3:0])
      4'h1:    code = (temp == 8'd0) ? ModeMaintain : ModeHeat;
      4'h2:    code = ModeCool;
      4'h3:    code = ModeDry;
      4'h4:    code = ModeIon;
      default: code = ModeUnknown;
    endcase
    return code;
  endfunction

  function automatic fan_e fan_code(input logic [7:0] b);
    fan_e code;
    unique case (b[7:4])
      4'h2:    code = FanAuto;
      4'h3:    code = FanSpeed1;
      4'h5:    code = FanSpeed2;
      4'h7:    code = FanSpeed3;
      4'h6:    code = FanSpeed4;
      default: code = FanUnknown;
    endcase
    return code;
  endfunction

  function automatic flap_e flap_code(input logic [7:0] b);
    flap_e code;
    unique case (b[3:0])
      4'h8:    code = FlapAuto;
      4'h9:    code = FlapTop;
      4'hA:    code = FlapTopMiddle;
      4'hB:    code = FlapMiddle;
      4'hC:    code = FlapMiddleDown;
      4'hF:    code = FlapDown;
      default: code = FlapUnknown;
    endcase
    return code;
  endfunction

endpackage

/* sv/ac_remote_frame_decoder.sv */
// ac_remote_frame_decoder: byte-serial decoder for one air-conditioner remote frame
// depends on acrfd_pkg for frame constants and code lookups
//
//   channel | direction | handshake                | payload
//   --------+-----------+--------------------------+--------------------------------------
//   in      | sink      | in_valid_i / in_ready_o   | frame_byte_i, last_byte_i
//   out     | source    | out_valid_o / out_ready_i | recognized_o .. received_checksum_o
//
// one byte is taken per cycle while in_ready_o is high; a transaction carrying the last byte loads the result
// register at that edge, so the result shows in the next cycle
// the frame state and the result register are separate; input stalls whenever a result
// is held and not taken, whatever byte is offered (in_ready_o low while out_valid_o high
// and out_ready_i low); a result taken in the same cycle frees the register at once
// reset clears the frame state and the result valid flag
`timescale 1ns / 1ps

module ac_remote_frame_decoder (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // byte stream in
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  logic [7:0]            frame_byte_i,
  input  logic                  last_byte_i,
  // decoded frame out
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic                  recognized_o,
  output logic [1:0]            power_state_o,
  output logic [2:0]            operating_mode_o,
  output logic [8:0]            temperature_o,
  output logic [2:0]            fan_setting_o,
  output logic [2:0]            flap_position_o,
  output logic                  checksum_ok_o,
  output logic [3:0]            computed_checksum_o,
  output logic [3:0]            received_checksum_o
);

  import acrfd_pkg::*;

  // frame state
  logic [3:0] pos_q, pos_d;
  logic       hdr_ok_q, hdr_ok_d;
  logic [7:0] acc_q, acc_d;
  logic [7:0] temp_byte_q, temp_byte_d;
  logic [7:0] power_byte_q, power_byte_d;
  logic [7:0] mode_fan_byte_q, mode_fan_byte_d;
  logic [7:0] flap_byte_q, flap_byte_d;

  // result register
  logic       out_valid_q, out_valid_d;
  logic       recog_q, recog_d;
  logic [1:0] power_q, power_d;
  logic [2:0] mode_q, mode_d;
  logic [8:0] temp_q, temp_d;
  logic [2:0] fan_q, fan_d;
  logic [2:0] flap_q, flap_d;
  logic       csum_ok_q, csum_ok_d;
  logic [3:0] csum_calc_q, csum_calc_d;
  logic [3:0] csum_recv_q, csum_recv_d;

  logic       in_fire;
  logic       load_result;
  logic       hdr_now;
  logic [7:0] acc_now;
  logic [3:0] calc_nib;
  logic [3:0] recv_nib;

  // a held result blocks input only because a last byte would overwrite it
  assign in_ready_o  = !out_valid_q || out_ready_i;
  assign in_fire     = in_valid_i && in_ready_o;
  assign load_result = in_fire && last_byte_i;

  always_comb begin
    // header check on bytes 0..2
    hdr_now = hdr_ok_q;
    if ((pos_q == PosHdr0 && frame_byte_i != Hdr0Byte) ||
        (pos_q == PosHdr1 && frame_byte_i != Hdr1Byte) ||
        (pos_q == PosHdr2 && frame_byte_i != Hdr2Byte)) begin
      hdr_now = 1'b0;
    end

    // running xor: whole bytes up to 11, low nibble of byte 12, nothing after
    priority if (pos_q < PosChecksum) begin
      acc_now = acc_q ^ frame_byte_i;
    end else if (pos_q == PosChecksum) begin
      acc_now = acc_q ^ {4'h0, frame_byte_i[3:0]};
    end else begin
      acc_now = acc_q;
    end

    calc_nib = acc_now[7:4] ^ acc_now[3:0];
    recv_nib = frame_byte_i[7:4];

    // field capture
    temp_byte_d     = (pos_q == PosTemp)    ? frame_byte_i : temp_byte_q;
    power_byte_d    = (pos_q == PosPower)   ? frame_byte_i : power_byte_q;
    mode_fan_byte_d = (pos_q == PosModeFan) ? frame_byte_i : mode_fan_byte_q;
    flap_byte_d     = (pos_q == PosFlap)    ? frame_byte_i : flap_byte_q;
    hdr_ok_d        = hdr_now;
    acc_d           = acc_now;
    pos_d           = (pos_q == PosMax) ? pos_q : pos_q + 4'd1;

    // a last byte returns the frame state to its reset value
    if (last_byte_i) begin
      pos_d           = '0;
      hdr_ok_d        = 1'b1;
      acc_d           = '0;
      temp_byte_d     = '0;
      power_byte_d    = '0;
      mode_fan_byte_d = '0;
      flap_byte_d     = '0;
    end

    // result fields; all zero unless 13 bytes with a good header
    recog_d     = 1'b0;
    power_d     = '0;
    mode_d      = '0;
    temp_d      = '0;
    fan_d       = '0;
    flap_d      = '0;
    csum_ok_d   = 1'b0;
    csum_calc_d = '0;
    csum_recv_d = '0;
    if (pos_q == PosChecksum && hdr_ok_q) begin
      recog_d     = 1'b1;
      power_d     = power_code(power_byte_q);
      mode_d      = mode_code(mode_fan_byte_q, temp_byte_q);
      temp_d      = (temp_byte_q == 8'd0) ? TempMaintain : {1'b0, temp_byte_q} + TempOffset;
      fan_d       = fan_code(mode_fan_byte_q);
      flap_d      = flap_code(flap_byte_q);
      csum_ok_d   = (calc_nib == recv_nib);
      csum_calc_d = calc_nib;
      csum_recv_d = recv_nib;
    end

    // result valid: set by a last byte, dropped when taken
    priority if (load_result) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q           <= '0;
      hdr_ok_q        <= 1'b1;
      acc_q           <= '0;
      temp_byte_q     <= '0;
      power_byte_q    <= '0;
      mode_fan_byte_q <= '0;
      flap_byte_q     <= '0;
      out_valid_q     <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
      if (in_fire) begin
        pos_q           <= pos_d;
        hdr_ok_q        <= hdr_ok_d;
        acc_q           <= acc_d;
        temp_byte_q     <= temp_byte_d;
        power_byte_q    <= power_byte_d;
        mode_fan_byte_q <= mode_fan_byte_d;
        flap_byte_q     <= flap_byte_d;
      end
    end
  end

  // result payload, no reset needed
  always_ff @(posedge clk_i) begin
    if (load_result) begin
      recog_q     <= recog_d;
      power_q     <= power_d;
      mode_q      <= mode_d;
      temp_q      <= temp_d;
      fan_q       <= fan_d;
      flap_q      <= flap_d;
      csum_ok_q   <= csum_ok_d;
      csum_calc_q <= csum_calc_d;
      csum_recv_q <= csum_recv_d;
    end
  end

  assign out_valid_o         = out_valid_q;
  assign recognized_o        = recog_q;
  assign power_state_o       = power_q;
  assign operating_mode_o    = mode_q;
  assign temperature_o       = temp_q;
  assign fan_setting_o       = fan_q;
  assign flap_position_o     = flap_q;
  assign checksum_ok_o       = csum_ok_q;
  assign computed_checksum_o = csum_calc_q;
  assign received_checksum_o = csum_recv_q;

endmodule

/* tb/sv/tb.sv */
// tb: self-checking testbench for ac_remote_frame_decoder
// byte stream in, one decoded result per frame out
// depends on acrfd_pkg (result enums, frame positions, header bytes) and the decoder RTL
`timescale 1ns / 1ps

module tb;
  import acrfd_pkg::*;

  localparam int ItemsTarget   = 850;
  localparam int WatchdogLimit = 2000;
  localparam int DrainCycles   = 10;

  typedef struct {
    logic [7:0] data;
    logic       last;
    logic       hold;   // offer only once every pending result has come back
  } byte_item_t;

  typedef struct {
    logic       recognized;
    power_e     power;
    mode_e      mode;
    logic [8:0] temp;
    fan_e       fan;
    flap_e      flap;
    logic       ck_ok;
    logic [3:0] ck_calc;
    logic [3:0] ck_recv;
  } frame_result_t;

  logic       clk_i         = 1'b0;
  logic       rst_ni        = 1'b0;
  logic       in_valid_i    = 1'b0;
  logic [7:0] frame_byte_i  = 8'h00;
  logic       last_byte_i   = 1'b0;
  logic       out_ready_i   = 1'b0;
  logic       in_ready_o;
  logic       out_valid_o;
  logic       recognized_o;
  logic [1:0] power_state_o;
  logic [2:0] operating_mode_o;
  logic [8:0] temperature_o;
  logic [2:0] fan_setting_o;
  logic [2:0] flap_position_o;
  logic       checksum_ok_o;
  logic [3:0] computed_checksum_o;
  logic [3:0] received_checksum_o;

  ac_remote_frame_decoder i_dut (
    .clk_i,
    .rst_ni,
    .in_valid_i,
    .in_ready_o,
    .frame_byte_i,
    .last_byte_i,
    .out_valid_o,
    .out_ready_i,
    .recognized_o,
    .power_state_o,
    .operating_mode_o,
    .temperature_o,
    .fan_setting_o,
    .flap_position_o,
    .checksum_ok_o,
    .computed_checksum_o,
    .received_checksum_o
  );

  always #5 clk_i = ~clk_i;

  byte_item_t    byte_queue[$];
  frame_result_t frame_results[$];
  logic [7:0]    frm_buf[0:19];

  // predictor copy of the frame state
  logic [3:0] frm_pos     = 4'd0;
  logic       frm_hdr_ok  = 1'b1;
  logic [7:0] frm_xor     = 8'h00;
  logic [7:0] frm_temp    = 8'h00;
  logic [7:0] frm_power   = 8'h00;
  logic [7:0] frm_modefan = 8'h00;
  logic [7:0] frm_flap    = 8'h00;

  int errors        = 0;
  int bytes_taken   = 0;
  int results_seen  = 0;
  int recog_seen    = 0;
  int ck_match_seen = 0;
  int idle_cycles   = 0;

  // ---------------------------------------------------------------------------
  // code tables
  // ---------------------------------------------------------------------------
  function automatic power_e power_of(input logic [7:0] b);
    if (b == 8'h21) return PowerOff;
    if (b == 8'h31) return PowerOn;
    if (b == 8'h81) return PowerTimerOff;
    return PowerUnknown;
  endfunction

  function automatic mode_e mode_of(input logic [7:0] b, input logic [7:0] t);
    if (b[3:0] == 4'h1) return (t == 8'h00) ? ModeMaintain : ModeHeat;
    if (b[3:0] == 4'h2) return ModeCool;
    if (b[3:0] == 4'h3) return ModeDry;
    if (b[3:0] == 4'h4) return ModeIon;
    return ModeUnknown;
  endfunction

  function automatic fan_e fan_of(input logic [7:0] b);
    if (b[7:4] == 4'h2) return FanAuto;
    if (b[7:4] == 4'h3) return FanSpeed1;
    if (b[7:4] == 4'h5) return FanSpeed2;
    if (b[7:4] == 4'h7) return FanSpeed3;
    if (b[7:4] == 4'h6) return FanSpeed4;
    return FanUnknown;
  endfunction

  function automatic flap_e flap_of(input logic [7:0] b);
    if (b[3:0] == 4'h8) return FlapAuto;
    if (b[3:0] == 4'h9) return FlapTop;
    if (b[3:0] == 4'hA) return FlapTopMiddle;
    if (b[3:0] == 4'hB) return FlapMiddle;
    if (b[3:0] == 4'hC) return FlapMiddleDown;
    if (b[3:0] == 4'hF) return FlapDown;
    return FlapUnknown;
  endfunction

  // advance the frame state by one accepted byte; a last byte queues the decoded result
  task automatic track_frame_byte(input logic [7:0] b, input logic last);
    frame_result_t r;
    logic [3:0]    at;
    logic [3:0]    calc;
    at = frm_pos;
    if (at == PosHdr0 && b != Hdr0Byte) frm_hdr_ok = 1'b0;
    if (at == PosHdr1 && b != Hdr1Byte) frm_hdr_ok = 1'b0;
    if (at == PosHdr2 && b != Hdr2Byte) frm_hdr_ok = 1'b0;
    if (at == PosTemp) frm_temp = b;
    if (at == PosPower) frm_power = b;
    if (at == PosModeFan) frm_modefan = b;
    if (at == PosFlap) frm_flap = b;
    if (at < PosChecksum) frm_xor = frm_xor ^ b;
    else if (at == PosChecksum) frm_xor = frm_xor ^ {4'h0, b[3:0]};
    if (at != PosMax) frm_pos = at + 4'd1;
    if (last) begin
      r.recognized = 1'b0;
      r.power      = PowerUnknown;
      r.mode       = ModeUnknown;
      r.temp       = 9'd0;
      r.fan        = FanUnknown;
      r.flap       = FlapUnknown;
      r.ck_ok      = 1'b0;
      r.ck_calc    = 4'h0;
      r.ck_recv    = 4'h0;
      if (at == PosChecksum && frm_hdr_ok) begin
        calc         = frm_xor[7:4] ^ frm_xor[3:0];
        r.recognized = 1'b1;
        r.power      = power_of(frm_power);
        r.mode       = mode_of(frm_modefan, frm_temp);
        r.temp       = (frm_temp == 8'h00) ? TempMaintain : {1'b0, frm_temp} + TempOffset;
        r.fan        = fan_of(frm_modefan);
        r.flap       = flap_of(frm_flap);
        r.ck_calc    = calc;
        r.ck_recv    = b[7:4];
        r.ck_ok      = (calc == b[7:4]);
      end
      frame_results.push_back(r);
      frm_pos     = 4'd0;
      frm_hdr_ok  = 1'b1;
      frm_xor     = 8'h00;
      frm_temp    = 8'h00;
      frm_power   = 8'h00;
      frm_modefan = 8'h00;
      frm_flap    = 8'h00;
    end
  endtask

  // ---------------------------------------------------------------------------
  // frame builders
  // ---------------------------------------------------------------------------
  function automatic logic [7:0] pick_temp_byte();
    case ($urandom_range(0, 7))
      0:       return 8'h00;
      1:       return 8'hFF;
      default: return 8'($urandom);
    endcase
  endfunction

  function automatic logic [7:0] pick_power_byte();
    case ($urandom_range(0, 4))
      0:       return 8'h21;
      1:       return 8'h31;
      2:       return 8'h81;
      default: return 8'($urandom);
    endcase
  endfunction

  function automatic logic [7:0] pick_mode_fan_byte();
    logic [3:0] hi;
    logic [3:0] lo;
    case ($urandom_range(0, 6))
      0:       hi = 4'h2;
      1:       hi = 4'h3;
      2:       hi = 4'h5;
      3:       hi = 4'h7;
      4:       hi = 4'h6;
      default: hi = 4'($urandom);
    endcase
    case ($urandom_range(0, 5))
      0:       lo = 4'h1;
      1:       lo = 4'h2;
      2:       lo = 4'h3;
      3:       lo = 4'h4;
      default: lo = 4'($urandom);
    endcase
    return {hi, lo};
  endfunction

  function automatic logic [7:0] pick_flap_byte();
    logic [3:0] lo;
    case ($urandom_range(0, 7))
      0:       lo = 4'h8;
      1:       lo = 4'h9;
      2:       lo = 4'hA;
      3:       lo = 4'hB;
      4:       lo = 4'hC;
      5:       lo = 4'hF;
      default: lo = 4'($urandom);
    endcase
    return {4'($urandom), lo};
  endfunction

  // 13-byte frame with a good header; ck_good puts the matching nibble in byte 12
  task automatic build_sane_frame(input logic [7:0] t, input logic [7:0] p,
                                  input logic [7:0] mf, input logic [7:0] fl,
                                  input logic ck_good);
    logic [7:0] acc;
    logic [3:0] calc;
    frm_buf[0]  = Hdr0Byte;
    frm_buf[1]  = Hdr1Byte;
    frm_buf[2]  = Hdr2Byte;
    frm_buf[3]  = 8'($urandom);
    frm_buf[4]  = t;
    frm_buf[5]  = p;
    frm_buf[6]  = mf;
    frm_buf[7]  = 8'($urandom);
    frm_buf[8]  = fl;
    frm_buf[9]  = 8'($urandom);
    frm_buf[10] = 8'($urandom);
    frm_buf[11] = 8'($urandom);
    frm_buf[12] = 8'($urandom);
    acc = 8'h00;
    for (int i = 0; i < 12; i++) acc = acc ^ frm_buf[i];
    acc  = acc ^ {4'h0, frm_buf[12][3:0]};
    calc = acc[7:4] ^ acc[3:0];
    frm_buf[12][7:4] = ck_good ? calc : ~calc;
  endtask

  task automatic queue_frame(input int len, input logic hold);
    byte_item_t it;
    for (int i = 0; i < len; i++) begin
      it.data = frm_buf[i];
      it.last = (i == len - 1);
      it.hold = hold && (i == 0);
      byte_queue.push_back(it);
    end
  endtask

  // ---------------------------------------------------------------------------
  // checking
  // ---------------------------------------------------------------------------
  task automatic report_mismatch(input string msg);
    errors++;
    $display("[%0t] mismatch: %s", $realtime, msg);
  endtask

  task automatic check_field(input string name, input logic [8:0] got, input logic [8:0] want);
    if (got !== want)
      report_mismatch($sformatf("result %0d %s got %0d want %0d",
                                results_seen, name, got, want));
  endtask

  // ---------------------------------------------------------------------------
  // byte driver: bursts of random length, random gaps, optional drain hold
  // ---------------------------------------------------------------------------
  byte_item_t next_item;
  int         burst_left = 0;
  int         gap_left   = 0;

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && in_ready_o) begin
        track_frame_byte(frame_byte_i, last_byte_i);
        bytes_taken++;
      end
      if (!in_valid_i || in_ready_o) begin
        if (gap_left != 0) begin
          gap_left--;
          in_valid_i <= 1'b0;
        end else if (byte_queue.size() != 0 &&
                     !(byte_queue[0].hold && frame_results.size() != 0)) begin
          next_item = byte_queue.pop_front();
          in_valid_i   <= 1'b1;
          frame_byte_i <= next_item.data;
          last_byte_i  <= next_item.last;
          if (burst_left <= 1) begin
            burst_left = $urandom_range(1, 40);
            gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
          end else begin
            burst_left--;
          end
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // result monitor and receiver stall pattern
  // ---------------------------------------------------------------------------
  frame_result_t want;
  int            rx_cycle   = 0;
  int            stall_left = 0;

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) begin
        if (frame_results.size() == 0) begin
          report_mismatch("result transaction with no frame pending");
        end else begin
          want = frame_results.pop_front();
          check_field("recognized", 9'(recognized_o), 9'(want.recognized));
          check_field("power_state", 9'(power_state_o), 9'(want.power));
          check_field("operating_mode", 9'(operating_mode_o), 9'(want.mode));
          check_field("temperature", temperature_o, want.temp);
          check_field("fan_setting", 9'(fan_setting_o), 9'(want.fan));
          check_field("flap_position", 9'(flap_position_o), 9'(want.flap));
          check_field("checksum_ok", 9'(checksum_ok_o), 9'(want.ck_ok));
          check_field("computed_checksum", 9'(computed_checksum_o), 9'(want.ck_calc));
          check_field("received_checksum", 9'(received_checksum_o), 9'(want.ck_recv));
          if (want.recognized) recog_seen++;
          if (want.ck_ok) ck_match_seen++;
        end
        results_seen++;
      end
      rx_cycle++;
      // four stall regimes, taken in turn as the receive cycle counter advances
      if (stall_left != 0) begin
        stall_left--;
        out_ready_i <= 1'b0;
      end else begin
        case ((rx_cycle >> 8) % 4)
          0: out_ready_i <= 1'b1;
          1: out_ready_i <= ($urandom_range(0, 3) != 0);
          2: out_ready_i <= ($urandom_range(0, 3) == 0);
          default: begin
            if ($urandom_range(0, 7) == 0) begin
              stall_left = $urandom_range(4, 20);
              out_ready_i <= 1'b0;
            end else begin
              out_ready_i <= 1'b1;
            end
          end
        endcase
      end
    end
  end

  // ---------------------------------------------------------------------------
  // watchdog: no transaction on either channel for too long
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= WatchdogLimit) begin
        $display("[%0t] timeout: %0d bytes left to send, %0d results outstanding",
                 $realtime, byte_queue.size(), frame_results.size());
        $display("FAILURE");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // stimulus, reset and end of run
  // ---------------------------------------------------------------------------
  initial begin
    int   len;
    int   frame_no;
    logic hold;
    frame_no = 0;

    // recognized frame: zero temperature byte turns heat into maintenance heat,
    // timer off, fan auto, flap down, checksum matching
    build_sane_frame(8'h00, 8'h81, 8'h21, 8'h0F, 1'b1);
    queue_frame(13, 1'b0);
    // one-byte frame, sent only after the first result is back
    frm_buf[0] = 8'hFF;
    queue_frame(1, 1'b1);
    // recognized frame with the largest temperature, unlisted codes, bad checksum
    build_sane_frame(8'hFF, 8'h00, 8'hFF, 8'hF0, 1'b0);
    queue_frame(13, 1'b0);

    // mostly well-formed frames with random content, the rest noise and broken frames
    while (byte_queue.size() < ItemsTarget) begin
      frame_no++;
      hold = (frame_no % 16 == 0);
      build_sane_frame(pick_temp_byte(), pick_power_byte(), pick_mode_fan_byte(),
                       pick_flap_byte(), $urandom_range(0, 3) != 0);
      len = 13;
      case ($urandom_range(0, 9))
        0: len = $urandom_range(1, 12);
        1: begin
          len = $urandom_range(0, 2);
          frm_buf[len] = frm_buf[len] ^ 8'($urandom_range(1, 255));
          len = 13;
        end
        2: begin
          len = $urandom_range(14, 20);
          for (int i = 13; i < len; i++) frm_buf[i] = 8'($urandom);
        end
        3: begin
          len = $urandom_range(1, 13);
          for (int i = 0; i < len; i++) frm_buf[i] = 8'($urandom);
        end
        default: ;
      endcase
      queue_frame(len, hold);
    end

    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (byte_queue.size() != 0 || in_valid_i || frame_results.size() != 0)
      @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);

    $display("sent %0d bytes, checked %0d frame results: %0d recognized, %0d %s",
             bytes_taken, results_seen, recog_seen, ck_match_seen,
             "with matching checksum");
    $display("input gaps, output stalls and a full drain pause were mixed in; %0d mismatches",
             errors);
    if (errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
